@@ hw/rtl/pwm_pkg.sv @@
// ----------------------------------------------------------------------------
// pwm_pkg
// shared types, constants and helpers of the two-level page walk memory
// ----------------------------------------------------------------------------
package pwm_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int ROW_W     = ADDR_W - 2;
   localparam int ROWS      = (MEM_BYTES + 3) / 4;
   localparam int CSR_ADDR_W = 3;

   localparam logic [31:0] FRAME_MASK   = 32'hffff_f000;
   localparam logic [31:0] ENT_ACCESSED = 32'h0000_0020;
   localparam logic [31:0] ENT_DIRTY    = 32'h0000_0040;
   localparam int          ENT_PRESENT_BIT = 0;

   localparam logic [2:0] LEN_ENTRY = 3'd4;

   localparam logic REG_PAGING = 1'b0;
   localparam logic REG_PDB    = 1'b1;

   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_DIR   = 2'd1,
      FAULT_TABLE = 2'd2,
      FAULT_RANGE = 2'd3
   } fault_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_PDE,
      ST_PTE,
      ST_PDE_WR,
      ST_PTE_WR,
      ST_DATA,
      ST_RDATA,
      ST_DONE
   } walk_state_type;

   typedef struct packed {
      logic        func;
      logic [31:0] vaddr;
      logic [2:0]  size_bytes;
      logic [31:0] wdata;
   } req_item_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic [31:0] phys_addr;
      fault_type   fault;
   } rsp_item_type;

   typedef struct packed {
      logic        paging_enable;
      logic [31:0] page_dir_base;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        len;
      logic [31:0]       wdata;
   } mem_req_type;

   function automatic logic in_range(logic [31:0] addr, logic [2:0] len);
      return ({1'b0, addr} + 33'(len)) <= 33'(MEM_BYTES);
   endfunction

   function automatic logic [2:0] norm_len(logic [2:0] size);
      logic [2:0] n;
      n = size;
      if (size == 3'd0) begin
         n = 3'd1;
      end else if (size > 3'd4) begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic logic [31:0] len_mask(logic [2:0] len);
      logic [31:0] m;
      case (len)
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

@@ hw/rtl/pwm_if.sv @@
// ----------------------------------------------------------------------------
// pwm_if
// valid/ready channels for access requests and their responses
// ----------------------------------------------------------------------------
interface pwm_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] vaddr;
   logic [2:0]  size_bytes;
   logic [31:0] wdata;

   modport source (output valid, output func, output vaddr, output size_bytes,
                   output wdata, input ready);
   modport sink   (input valid, input func, input vaddr, input size_bytes,
                   input wdata, output ready);
endinterface

interface pwm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rdata;
   logic [31:0] phys_addr;
   logic [1:0]  fault;

   modport source (output valid, output rdata, output phys_addr, output fault,
                   input ready);
   modport sink   (input valid, input rdata, input phys_addr, input fault,
                   output ready);
endinterface

@@ hw/rtl/pwm_ram.sv @@
// ----------------------------------------------------------------------------
// pwm_ram
// generic single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module pwm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

@@ hw/rtl/pwm_mem.sv @@
// ----------------------------------------------------------------------------
// pwm_mem
// byte-addressed physical memory in four byte lanes, so that any access of
// one to four bytes, aligned or not, is a single memory operation
// ----------------------------------------------------------------------------
module pwm_mem (
   input  logic                 clock,
   input  pwm_pkg::mem_req_type req,
   output logic [31:0]          rdata
);

   logic [3:0][7:0] lane_q;
   logic [1:0]      a_lo_ff;

   for (genvar b = 0; b < 4; b++) begin : g_lane
      logic [1:0]                  off;
      logic [pwm_pkg::ADDR_W-1:0]  sum;
      logic                        lane_we;

      assign off     = 2'(b) - req.addr[1:0];
      assign sum     = req.addr + pwm_pkg::ADDR_W'(off);
      assign lane_we = req.we && (3'(off) < req.len);

      pwm_ram #(
         .DEPTH (pwm_pkg::ROWS),
         .WIDTH (8)
      ) u_ram (
         .clock (clock),
         .we    (lane_we),
         .addr  (sum[pwm_pkg::ADDR_W-1:2]),
         .wdata (req.wdata[8*off +: 8]),
         .rdata (lane_q[b])
      );
   end

   always_ff @(posedge clock) begin
      a_lo_ff <= req.addr[1:0];
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rdata[8*i +: 8] = lane_q[2'(a_lo_ff + 2'(i))];
      end
   end

endmodule

@@ hw/rtl/pwm_walk.sv @@
// ----------------------------------------------------------------------------
// pwm_walk
// access sequencer: directory and table entry reads, entry write-back and
// the data access, all through the single memory port
// ----------------------------------------------------------------------------
module pwm_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  pwm_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pwm_pkg::req_item_type req_item,
   output logic                  res_valid,
   input  logic                  res_ready,
   output pwm_pkg::rsp_item_type res_item,
   output pwm_pkg::mem_req_type  mem_req,
   input  logic [31:0]           mem_rdata
);

   pwm_pkg::walk_state_type state_ff, state_in;

   logic                func_ff, func_in;
   logic [31:0]         vaddr_ff, vaddr_in;
   logic [2:0]          len_ff, len_in;
   logic [31:0]         wdata_ff, wdata_in;
   logic [31:0]         pde_a_ff, pde_a_in;
   logic [31:0]         pte_a_ff, pte_a_in;
   logic [31:0]         pde_ff, pde_in;
   logic [31:0]         pte_ff, pte_in;
   logic [31:0]         pa_ff, pa_in;
   logic [31:0]         rdata_ff, rdata_in;
   pwm_pkg::fault_type  fault_ff, fault_in;

   logic [31:0] pde_a;
   logic [31:0] pte_a;
   logic [31:0] pa_walk;
   logic        pde_a_ok;
   logic        pte_a_ok;
   logic        pa_walk_ok;
   logic        va_ok;
   logic        present;

   assign pde_a      = {cfg.page_dir_base[31:12], vaddr_ff[31:22], 2'b00};
   assign pte_a      = {mem_rdata[31:12], vaddr_ff[21:12], 2'b00};
   assign pa_walk    = {mem_rdata[31:12], vaddr_ff[11:0]};
   assign pde_a_ok   = pwm_pkg::in_range(pde_a, pwm_pkg::LEN_ENTRY);
   assign pte_a_ok   = pwm_pkg::in_range(pte_a, pwm_pkg::LEN_ENTRY);
   assign pa_walk_ok = pwm_pkg::in_range(pa_walk, len_ff);
   assign va_ok      = pwm_pkg::in_range(vaddr_ff, len_ff);
   assign present    = mem_rdata[pwm_pkg::ENT_PRESENT_BIT];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pwm_pkg::ST_START;
            end
         end
         pwm_pkg::ST_START: begin
            if (cfg.paging_enable) begin
               state_in = pde_a_ok ? pwm_pkg::ST_PDE : pwm_pkg::ST_DONE;
            end else begin
               state_in = va_ok ? pwm_pkg::ST_DATA : pwm_pkg::ST_DONE;
            end
         end
         pwm_pkg::ST_PDE: begin
            state_in = (present && pte_a_ok) ? pwm_pkg::ST_PTE : pwm_pkg::ST_DONE;
         end
         pwm_pkg::ST_PTE: begin
            state_in = (present && pa_walk_ok) ? pwm_pkg::ST_PDE_WR : pwm_pkg::ST_DONE;
         end
         pwm_pkg::ST_PDE_WR: state_in = pwm_pkg::ST_PTE_WR;
         pwm_pkg::ST_PTE_WR: state_in = pwm_pkg::ST_DATA;
         pwm_pkg::ST_DATA: begin
            state_in = (func_ff == pwm_pkg::FUNC_WRITE) ? pwm_pkg::ST_DONE
                                                        : pwm_pkg::ST_RDATA;
         end
         pwm_pkg::ST_RDATA: state_in = pwm_pkg::ST_DONE;
         pwm_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = pwm_pkg::ST_IDLE;
            end
         end
         default: state_in = pwm_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory port
   always_comb begin
      func_in  = func_ff;
      vaddr_in = vaddr_ff;
      len_in   = len_ff;
      wdata_in = wdata_ff;
      pde_a_in = pde_a_ff;
      pte_a_in = pte_a_ff;
      pde_in   = pde_ff;
      pte_in   = pte_ff;
      pa_in    = pa_ff;
      rdata_in = rdata_ff;
      fault_in = fault_ff;

      mem_req.we    = 1'b0;
      mem_req.addr  = pa_ff[pwm_pkg::ADDR_W-1:0];
      mem_req.len   = pwm_pkg::LEN_ENTRY;
      mem_req.wdata = wdata_ff;

      req_ready = (state_ff == pwm_pkg::ST_IDLE);
      res_valid = (state_ff == pwm_pkg::ST_DONE);

      case (state_ff)
         pwm_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_item.func;
               vaddr_in = req_item.vaddr;
               len_in   = pwm_pkg::norm_len(req_item.size_bytes);
               wdata_in = req_item.wdata;
               rdata_in = '0;
               fault_in = pwm_pkg::FAULT_NONE;
            end
         end
         pwm_pkg::ST_START: begin
            if (cfg.paging_enable) begin
               pde_a_in     = pde_a;
               mem_req.addr = pde_a[pwm_pkg::ADDR_W-1:0];
               if (!pde_a_ok) begin
                  pa_in    = pde_a;
                  fault_in = pwm_pkg::FAULT_RANGE;
               end
            end else begin
               pa_in = vaddr_ff;
               if (!va_ok) begin
                  fault_in = pwm_pkg::FAULT_RANGE;
               end
            end
         end
         pwm_pkg::ST_PDE: begin
            pde_in       = mem_rdata | pwm_pkg::ENT_ACCESSED;
            pte_a_in     = pte_a;
            mem_req.addr = pte_a[pwm_pkg::ADDR_W-1:0];
            if (!present) begin
               pa_in    = pde_a_ff;
               fault_in = pwm_pkg::FAULT_DIR;
            end else if (!pte_a_ok) begin
               pa_in    = pte_a;
               fault_in = pwm_pkg::FAULT_RANGE;
            end
         end
         pwm_pkg::ST_PTE: begin
            pte_in = mem_rdata | pwm_pkg::ENT_ACCESSED |
                     ((func_ff == pwm_pkg::FUNC_WRITE) ? pwm_pkg::ENT_DIRTY : 32'h0);
            if (!present) begin
               pa_in    = pte_a_ff;
               fault_in = pwm_pkg::FAULT_TABLE;
            end else begin
               pa_in = pa_walk;
               if (!pa_walk_ok) begin
                  fault_in = pwm_pkg::FAULT_RANGE;
               end
            end
         end
         pwm_pkg::ST_PDE_WR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = pde_a_ff[pwm_pkg::ADDR_W-1:0];
            mem_req.wdata = pde_ff;
         end
         pwm_pkg::ST_PTE_WR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = pte_a_ff[pwm_pkg::ADDR_W-1:0];
            mem_req.wdata = pte_ff;
         end
         pwm_pkg::ST_DATA: begin
            mem_req.we  = (func_ff == pwm_pkg::FUNC_WRITE);
            mem_req.len = len_ff;
         end
         pwm_pkg::ST_RDATA: begin
            rdata_in = mem_rdata & pwm_pkg::len_mask(len_ff);
         end
         pwm_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase

      res_item.rdata     = rdata_ff;
      res_item.phys_addr = pa_ff;
      res_item.fault     = fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      vaddr_ff <= vaddr_in;
      len_ff   <= len_in;
      wdata_ff <= wdata_in;
      pde_a_ff <= pde_a_in;
      pte_a_ff <= pte_a_in;
      pde_ff   <= pde_in;
      pte_ff   <= pte_in;
      pa_ff    <= pa_in;
      rdata_ff <= rdata_in;
      fault_ff <= fault_in;
   end

`ifndef ASSERT_OFF
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff == pwm_pkg::ST_PDE_WR || state_ff == pwm_pkg::ST_PTE_WR ||
                      state_ff == pwm_pkg::ST_DATA))
      else $error("memory write outside a write state");

   a_wb_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == pwm_pkg::ST_PDE_WR |=> state_ff == pwm_pkg::ST_PTE_WR)
      else $error("table entry write-back does not follow directory write-back");

   a_fault_no_data: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_item.fault != pwm_pkg::FAULT_NONE) |-> res_item.rdata == '0)
      else $error("faulted transaction carries read data");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == pwm_pkg::ST_START)
      else $error("accepted transaction did not start");
`endif

endmodule

@@ hw/rtl/two_level_page_walk_memory_top.sv @@
// ----------------------------------------------------------------------------
// two_level_page_walk_memory_top
// byte-addressed physical memory behind a two-level page walker
// ----------------------------------------------------------------------------
// Each request transaction reads or writes 1 to 4 bytes. All work goes through
// one single-port memory built from four byte lanes, one memory operation per
// cycle, and the operations run in sequence: with paging on, a directory read,
// a table read, two entry write-backs and the data access; with paging off,
// only the data access. A read also registers its loaded data before the
// response. A fault ends the walk early. One transaction is handled at a time;
// the next is taken while the last response still waits in the output
// register. Memory content is undefined until written; there is no clearing
// pass after reset.
module two_level_page_walk_memory_top (
   input  logic                           clock,
   input  logic                           reset,
   pwm_req_if.sink                        req_bus,
   pwm_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pwm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   logic                  paging_ff, paging_in;
   logic [31:0]           pdb_ff, pdb_in;
   logic                  csr_wr;
   pwm_pkg::cfg_type      cfg;

   pwm_pkg::req_item_type req_item;
   pwm_pkg::rsp_item_type res_item;
   logic                  res_valid;
   logic                  res_ready;
   pwm_pkg::mem_req_type  mem_req;
   logic [31:0]           mem_rdata;

   logic                  rsp_valid_ff, rsp_valid_in;
   pwm_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      paging_in = paging_ff;
      pdb_in    = pdb_ff;
      if (csr_wr) begin
         if (paddr[2] == pwm_pkg::REG_PDB) begin
            pdb_in = pwdata;
         end else begin
            paging_in = pwdata[0];
         end
      end
      prdata = (paddr[2] == pwm_pkg::REG_PDB) ? pdb_ff : {31'b0, paging_ff};
   end

   assign cfg.paging_enable = paging_ff;
   assign cfg.page_dir_base = pdb_ff;

   assign req_item.func       = req_bus.func;
   assign req_item.vaddr      = req_bus.vaddr;
   assign req_item.size_bytes = req_bus.size_bytes;
   assign req_item.wdata      = req_bus.wdata;

   pwm_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_item  (req_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   pwm_mem u_mem (
      .clock (clock),
      .req   (mem_req),
      .rdata (mem_rdata)
   );

   // response output register
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.rdata     = rsp_item_ff.rdata;
   assign rsp_bus.phys_addr = rsp_item_ff.phys_addr;
   assign rsp_bus.fault     = rsp_item_ff.fault;

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_ff    <= 1'b0;
         pdb_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         paging_ff    <= paging_in;
         pdb_ff       <= pdb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

@@ dv/two_level_page_walk_memory_top_tb.sv @@
// ----------------------------------------------------------------------------
// two_level_page_walk_memory_top_tb
// self-checking bench for the two-level page walk memory
// ----------------------------------------------------------------------------
// The memory is first loaded end to end with flat word writes, so no later
// read touches an uninitialized byte. Two page directories and three page
// tables are then written over it, with mapped, absent and out-of-range
// entries. A mirror of the memory and the walker computes each response when
// its request is accepted, and a monitor compares every response field in
// order. Directed cases cover the memory edges, odd sizes, entry overlap and
// every fault code; random traffic runs under four idle/stall mixes, a long
// response hold-off and a full drain.
// ----------------------------------------------------------------------------
module two_level_page_walk_memory_top_tb;
   import pwm_pkg::*;

   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam logic        FUNC_READ   = 1'b0;
   localparam logic [31:0] PRESENT     = 32'h1 << ENT_PRESENT_BIT;
   localparam logic [31:0] DIR_A       = 32'h0000_1000;
   localparam logic [31:0] DIR_B       = 32'h0000_f000;
   localparam logic [31:0] TABLE_0     = 32'h0000_0000;
   localparam logic [31:0] TABLE_1     = 32'h0000_2000;
   localparam logic [31:0] TABLE_2     = 32'h0000_3000;

   typedef enum logic [1:0] {
      KIND_MAPPED,
      KIND_ABSENT,
      KIND_BEYOND
   } entry_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   pwm_req_if req_bus();
   pwm_rsp_if rsp_bus();

   two_level_page_walk_memory_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [7:0]   mem_image [MEM_BYTES];
   logic         pg_on;
   logic [31:0]  dir_base;
   rsp_item_type walk_results [$];
   rsp_item_type head;
   req_item_type last_req;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int fail_count    = 0;
   int checked       = 0;
   int translated    = 0;
   int cycle_count   = 0;
   int fault_seen [4];

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // memory mirror and walk
   // ------------------------------------------------------------------------
   function automatic logic fits_memory(logic [31:0] a, int n);
      return (33'(a) + 33'(n)) <= 33'(MEM_BYTES);
   endfunction

   function automatic logic [31:0] load_le(logic [31:0] a, int n);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < n; i++) begin
         v[8*i +: 8] = mem_image[a + i];
      end
      return v;
   endfunction

   function automatic void store_le(logic [31:0] a, int n, logic [31:0] v);
      for (int i = 0; i < n; i++) begin
         mem_image[a + i] = v[8*i +: 8];
      end
   endfunction

   function automatic rsp_item_type walk_and_access(req_item_type t);
      rsp_item_type r;
      int           n;
      logic [31:0]  pde_a;
      logic [31:0]  pte_a;
      logic [31:0]  pde;
      logic [31:0]  pte;
      n = t.size_bytes;
      if (n == 0) begin
         n = 1;
      end else if (n > 4) begin
         n = 4;
      end
      r.rdata     = '0;
      r.phys_addr = t.vaddr;
      r.fault     = FAULT_NONE;
      if (pg_on) begin
         pde_a = (dir_base & FRAME_MASK) + {20'h0, t.vaddr[31:22], 2'b00};
         if (!fits_memory(pde_a, 4)) begin
            r.phys_addr = pde_a;
            r.fault     = FAULT_RANGE;
            return r;
         end
         pde = load_le(pde_a, 4);
         if (!pde[ENT_PRESENT_BIT]) begin
            r.phys_addr = pde_a;
            r.fault     = FAULT_DIR;
            return r;
         end
         pte_a = (pde & FRAME_MASK) + {20'h0, t.vaddr[21:12], 2'b00};
         if (!fits_memory(pte_a, 4)) begin
            r.phys_addr = pte_a;
            r.fault     = FAULT_RANGE;
            return r;
         end
         pte = load_le(pte_a, 4);
         if (!pte[ENT_PRESENT_BIT]) begin
            r.phys_addr = pte_a;
            r.fault     = FAULT_TABLE;
            return r;
         end
         pde = pde | ENT_ACCESSED;
         pte = pte | ENT_ACCESSED;
         if (t.func == FUNC_WRITE) begin
            pte = pte | ENT_DIRTY;
         end
         r.phys_addr = (pte & FRAME_MASK) + {20'h0, t.vaddr[11:0]};
         if (!fits_memory(r.phys_addr, n)) begin
            r.fault = FAULT_RANGE;
            return r;
         end
         // directory entry first, so a shared word ends up with the table entry
         store_le(pde_a, 4, pde);
         store_le(pte_a, 4, pte);
      end else if (!fits_memory(r.phys_addr, n)) begin
         r.fault = FAULT_RANGE;
         return r;
      end
      if (t.func == FUNC_WRITE) begin
         store_le(r.phys_addr, n, t.wdata);
      end else begin
         r.rdata = load_le(r.phys_addr, n);
      end
      return r;
   endfunction

   function automatic logic [31:0] make_entry(entry_kind_type kind, logic [31:0] frame);
      logic [31:0] flags;
      flags = $urandom() & 32'h0000_0ffe;
      case (kind)
         KIND_MAPPED: begin
            return (frame & FRAME_MASK) | flags | PRESENT;
         end
         KIND_ABSENT: begin
            return $urandom() & ~PRESENT;
         end
         default: begin
            return (32'($urandom_range(32'h000f_ffff, 16)) << 12) | flags | PRESENT;
         end
      endcase
   endfunction

   function automatic logic [31:0] vpage(int dir, int page, int offs);
      return {dir[9:0], page[9:0], offs[11:0]};
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_access(input req_item_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= t.func;
      req_bus.vaddr      <= t.vaddr;
      req_bus.size_bytes <= t.size_bytes;
      req_bus.wdata      <= t.wdata;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      walk_results.push_back(walk_and_access(t));
      if (pg_on) begin
         translated++;
      end
      last_req = t;
      @(negedge clock);
   endtask

   task automatic access(input logic func, input logic [31:0] vaddr,
                         input logic [2:0] size, input logic [31:0] wdata);
      req_item_type t;
      t.func       = func;
      t.vaddr      = vaddr;
      t.size_bytes = size;
      t.wdata      = wdata;
      send_access(t);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (walk_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // write then read back one register over the apb port
   task automatic set_register(input logic sel, input logic [31:0] value);
      logic [31:0] want;
      wait_idle();
      if (sel == REG_PDB) begin
         dir_base = value;
      end else begin
         pg_on = value[0];
      end
      want = (sel == REG_PDB) ? dir_base : {31'h0, pg_on};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      if (prdata !== want) begin
         $error("prdata of register %0d: expected %h, actual %h", sel, want, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_random(input int count);
      req_item_type t;
      int           pick;
      for (int k = 0; k < count; k++) begin
         pick         = $urandom_range(99);
         t.func       = 1'($urandom_range(1));
         t.wdata      = $urandom();
         t.vaddr      = $urandom();
         t.size_bytes = ($urandom_range(4) == 0) ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(4, 1));
         if (pick < 20) begin
            // revisit the last address, entries now carry accessed/dirty bits
            t.vaddr = last_req.vaddr;
         end else if (!pg_on) begin
            if (pick < 85) begin
               t.vaddr = $urandom_range(MEM_BYTES - 1);
            end
         end else if (pick < 70) begin
            t.vaddr[31:22] = ($urandom_range(1) == 0) ? 10'd0 : 10'd1023;
         end
         send_access(t);
      end
   endtask

   // ------------------------------------------------------------------------
   // setup
   // ------------------------------------------------------------------------
   task automatic load_memory();
      for (int a = 0; a < MEM_BYTES; a += 4) begin
         access(FUNC_WRITE, a, 3'd4, $urandom());
      end
   endtask

   task automatic write_level(input logic [31:0] base, input logic is_dir);
      entry_kind_type kind;
      logic [31:0]    frame;
      int             pick;
      for (int i = 0; i < 1024; i++) begin
         pick  = $urandom_range(99);
         frame = 32'($urandom_range(15)) << 12;
         if (pick < 70) begin
            kind = KIND_MAPPED;
         end else if (pick < 85) begin
            kind = KIND_ABSENT;
         end else begin
            kind = KIND_BEYOND;
         end
         if (is_dir && pick < 60) begin
            case ($urandom_range(2))
               0:       frame = TABLE_0;
               1:       frame = TABLE_1;
               default: frame = TABLE_2;
            endcase
         end
         case (i)
            0: begin
               kind = KIND_MAPPED;
               if (is_dir) begin
                  frame = TABLE_1;
               end
            end
            1: kind = KIND_ABSENT;
            2: kind = KIND_BEYOND;
            3: if (!is_dir) begin
               kind  = KIND_MAPPED;
               frame = 32'h0000_f000;
            end
            4: if (!is_dir) begin
               kind  = KIND_MAPPED;
               frame = base;
            end
            1023: begin
               kind = KIND_MAPPED;
               if (is_dir) begin
                  frame = TABLE_2;
               end
            end
            default: ;
         endcase
         access(FUNC_WRITE, base + 4 * i, 3'd4, make_entry(kind, frame));
      end
   endtask

   task automatic build_page_tables();
      write_level(DIR_A, 1'b1);
      write_level(DIR_B, 1'b1);
      write_level(TABLE_0, 1'b0);
      write_level(TABLE_1, 1'b0);
      write_level(TABLE_2, 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_flat_edges();
      send_idle_pct = 22;
      rsp_stall_pct = 22;
      set_register(REG_PAGING, 32'h0);
      access(FUNC_WRITE, 32'h0000_0000, 3'd4, 32'hffff_ffff);
      access(FUNC_READ,  32'h0000_0000, 3'd4, 32'h0);
      access(FUNC_WRITE, 32'h0000_0000, 3'd0, 32'h0);
      access(FUNC_READ,  32'h0000_0000, 3'd4, 32'hffff_ffff);
      access(FUNC_WRITE, 32'h0000_fffc, 3'd7, $urandom());
      access(FUNC_READ,  32'h0000_fffc, 3'd5, 32'h0);
      access(FUNC_READ,  32'h0000_fffd, 3'd4, 32'h0);
      access(FUNC_WRITE, 32'h0000_ffff, 3'd1, $urandom());
      access(FUNC_WRITE, 32'h0000_ffff, 3'd2, $urandom());
      access(FUNC_READ,  32'hffff_ffff, 3'd6, 32'h0);
      access(FUNC_READ,  32'h0000_1235, 3'd3, 32'h0);
   endtask

   task automatic test_walk_faults();
      set_register(REG_PAGING, 32'h1);
      set_register(REG_PDB, DIR_A | 32'h0000_0fff);
      access(FUNC_READ,  vpage(0, 0, 0), 3'd4, 32'h0);
      access(FUNC_WRITE, vpage(0, 0, 12'h7ff), 3'd2, $urandom());
      access(FUNC_READ,  vpage(0, 0, 12'h7ff), 3'd6, 32'h0);
      access(FUNC_READ,  vpage(1, 5, 0), 3'd4, 32'h0);
      access(FUNC_READ,  vpage(2, 5, 0), 3'd4, 32'h0);
      access(FUNC_READ,  vpage(0, 1, 0), 3'd4, 32'h0);
      access(FUNC_WRITE, vpage(0, 2, 0), 3'd4, $urandom());
      access(FUNC_READ,  vpage(0, 3, 12'hffc), 3'd4, 32'h0);
      access(FUNC_READ,  vpage(0, 3, 12'hffe), 3'd4, 32'h0);
      // data lands on its own table entry after the entry write-back
      access(FUNC_WRITE, vpage(0, 4, 16), 3'd4, $urandom() | PRESENT);
      access(FUNC_READ,  vpage(0, 4, 16), 3'd4, 32'h0);
      access(FUNC_READ,  32'hffff_ffff, 3'd1, 32'h0);
      set_register(REG_PDB, 32'hffff_ffff);
      access(FUNC_READ,  vpage(0, 0, 0), 3'd4, 32'h0);
      set_register(REG_PDB, 32'h0);
      access(FUNC_WRITE, $urandom(), 3'd3, $urandom());
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_register(REG_PDB, DIR_A);
      hold_left = 300;
      send_random(30);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      set_register(REG_PDB, DIR_A);
      send_random(100);
      send_idle_pct = 54;
      rsp_stall_pct = 0;
      set_register(REG_PAGING, 32'h0);
      send_random(100);
      send_idle_pct = 0;
      rsp_stall_pct = 54;
      set_register(REG_PAGING, 32'h1);
      set_register(REG_PDB, DIR_B);
      send_random(100);
      // a page table doubling as the directory
      send_idle_pct = 22;
      rsp_stall_pct = 22;
      set_register(REG_PDB, TABLE_1);
      send_random(100);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (walk_results.size() == 0) begin
            $error("response transaction with no request outstanding");
            fail_count++;
         end else begin
            head = walk_results.pop_front();
            checked++;
            fault_seen[head.fault]++;
            if (rsp_bus.rdata !== head.rdata) begin
               $error("rdata: expected %h, actual %h", head.rdata, rsp_bus.rdata);
               fail_count++;
            end
            if (rsp_bus.phys_addr !== head.phys_addr) begin
               $error("phys_addr: expected %h, actual %h", head.phys_addr,
                      rsp_bus.phys_addr);
               fail_count++;
            end
            if (rsp_bus.fault !== head.fault) begin
               $error("fault: expected %0d, actual %0d", head.fault, rsp_bus.fault);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_READ;
      req_bus.vaddr      = '0;
      req_bus.size_bytes = 3'd1;
      req_bus.wdata      = '0;
      rsp_bus.ready      = 1'b0;
      pg_on              = 1'b0;
      dir_base           = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      set_register(REG_PAGING, 32'h0);
      set_register(REG_PDB, 32'h0);
      load_memory();
      build_page_tables();
      test_flat_edges();
      test_walk_faults();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (20) @(negedge clock);
      $display("%0d responses checked, %0d through the walker; faults: dir %0d, table %0d, range %0d",
               checked, translated, fault_seen[FAULT_DIR], fault_seen[FAULT_TABLE],
               fault_seen[FAULT_RANGE]);
      $display("flat and translated access, memory edges, odd sizes, four stall mixes, hold-off");
      if (fail_count == 0 && walk_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ two_level_page_walk_memory_top.f @@
hw/rtl/pwm_pkg.sv
hw/rtl/pwm_if.sv
hw/rtl/pwm_ram.sv
hw/rtl/pwm_mem.sv
hw/rtl/pwm_walk.sv
hw/rtl/two_level_page_walk_memory_top.sv
dv/two_level_page_walk_memory_top_tb.sv
